FILE: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths and constants for the 64-bit modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WORD_BITS = 64;
  localparam int CNT_W     = $clog2(WORD_BITS);

  localparam logic [63:0] RESET_MODULUS_FULL = 64'd953467954114363;
  localparam logic [WORD_BITS-1:0] RESET_MODULUS = RESET_MODULUS_FULL[WORD_BITS-1:0];

  localparam logic [WORD_BITS-1:0] WORD_ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};

endpackage

FILE: design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// WORD_BITS bits per product. A zero modulus acts as 2^WORD_BITS.
// ----------------------------------------------------------------------------
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] y,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] a_sh;
  logic [WORD_BITS-1:0] y_reg;
  logic [WORD_BITS:0]   m_ext;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] r_next;

  logic [WORD_BITS+1:0] t;
  logic [WORD_BITS+1:0] m1;
  logic [WORD_BITS+1:0] m2;
  logic [WORD_BITS+1:0] d1;
  logic [WORD_BITS+1:0] d2;

  always_comb begin
    t  = {1'b0, r, 1'b0} + {2'b00, (a_sh[WORD_BITS-1] ? y_reg : {WORD_BITS{1'b0}})};
    m1 = {1'b0, m_ext};
    m2 = {m_ext, 1'b0};
    d1 = t - m1;
    d2 = t - m2;
    if (t >= m2) begin
      r_next = d2[WORD_BITS-1:0];
    end else if (t >= m1) begin
      r_next = d1[WORD_BITS-1:0];
    end else begin
      r_next = t[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WORD_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      y_reg <= y;
      r     <= '0;
      m_ext <= (m == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, m};
    end else if (busy) begin
      a_sh <= a_sh << 1;
      r    <= r_next;
    end
  end

  assign result = r;

endmodule

FILE: design/modular_exponentiation_64.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_64
// power = base^exponent mod modulus by right-to-left square-and-multiply on
// one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
//  channel  | signals                            | direction
//  ---------+------------------------------------+----------
//  input    | in_valid, in_stall, base, exponent | in
//  output   | out_valid, out_stall, power        | out
//  config   | cfg_write, cfg_data (modulus)      | in
//
//  An item takes one reduction, WORD_BITS squarings and one multiply per set
//  exponent bit, all on the shared multiplier. in_stall is high while an
//  item runs. A finished result waits in the output register while a new
//  item runs. rst is synchronous; modulus resets to 953467954114363.
// ----------------------------------------------------------------------------
module modular_exponentiation_64
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] power,
  input  logic                 cfg_write,
  input  logic [WORD_BITS-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_SQR    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] e_sh;
  logic [CNT_W-1:0]     bit_cnt;
  logic                 start;

  logic [WORD_BITS-1:0] op_a;
  logic [WORD_BITS-1:0] op_y;
  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_res;
  logic                 in_xfer;
  logic                 out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (state)
      ST_REDUCE: begin
        op_a = b;
        op_y = WORD_ONE;
      end
      ST_MUL: begin
        op_a = acc;
        op_y = b;
      end
      default: begin
        op_a = b;
        op_y = b;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .a      (op_a),
    .y      (op_y),
    .m      (modulus),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_MODULUS;
    end else if (cfg_write) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
    end else begin
      start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state   <= ST_REDUCE;
            start   <= 1'b1;
            bit_cnt <= CNT_W'(WORD_BITS - 1);
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            state <= e_sh[0] ? ST_MUL : ST_SQR;
            start <= 1'b1;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_SQR;
            start <= 1'b1;
          end
        end
        ST_SQR: begin
          if (mul_done) begin
            if (bit_cnt == '0) begin
              state <= ST_FINISH;
            end else begin
              bit_cnt <= bit_cnt - 1'b1;
              state   <= e_sh[1] ? ST_MUL : ST_SQR;
              start   <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b    <= base;
      e_sh <= exponent;
      acc  <= WORD_ONE;
    end else if (mul_done) begin
      if (state == ST_MUL) begin
        acc <= mul_res;
      end else begin
        b <= mul_res;
      end
      if (state == ST_SQR) begin
        e_sh <= e_sh >> 1;
      end
    end
    if (state == ST_FINISH && out_free) begin
      power <= acc;
    end
  end

endmodule

FILE: design/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for modular_exponentiation_64, bound to the top level.
// ----------------------------------------------------------------------------
module mexp_checker
  import mexp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_BITS-1:0] power
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power))
    else $error("stalled output transfer changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input not stalled while item runs");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a running item");

  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("input not reopened when result delivered");

endmodule

bind modular_exponentiation_64 mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .power     (power)
);

FILE: tb/mexp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mexp_scoreboard
// Watches the input, output and modulus ports of modular_exponentiation_64.
// Every input transfer queues base^exponent mod modulus as predicted here
// with exact double-width products. Every output transfer is compared
// against the oldest queued value.
// ----------------------------------------------------------------------------
module mexp_scoreboard
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WORD_BITS-1:0] power,
  input  logic                 cfg_write,
  input  logic [WORD_BITS-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  logic [WORD_BITS-1:0] modulus_q;
  logic [WORD_BITS-1:0] pending_powers[$];
  logic [WORD_BITS-1:0] want;

  function automatic logic [WORD_BITS-1:0] mod_pow(input logic [WORD_BITS-1:0] b,
                                                   input logic [WORD_BITS-1:0] e,
                                                   input logic [WORD_BITS-1:0] m);
    logic [2*WORD_BITS-1:0] m_wide;
    logic [2*WORD_BITS-1:0] acc;
    logic [2*WORD_BITS-1:0] sq;
    m_wide = {{WORD_BITS{1'b0}}, m};
    acc    = {{(2*WORD_BITS-1){1'b0}}, 1'b1};
    sq     = {{WORD_BITS{1'b0}}, b} % m_wide;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % m_wide;
      end
      sq = (sq * sq) % m_wide;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    modulus_q   = RESET_MODULUS;
  end

  always @(posedge clk) begin
    if (rst) begin
      modulus_q = RESET_MODULUS;
      pending_powers.delete();
    end else begin
      if (cfg_write) begin
        modulus_q = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (pending_powers.size() == 0) begin
          $error("power transfer with nothing pending: actual %h", power);
          mismatches++;
        end else begin
          want = pending_powers.pop_front();
          if (power !== want) begin
            $error("power mismatch: expected %h, actual %h", want, power);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_powers.push_back(mod_pow(base, exponent, modulus_q));
      end
    end
    outstanding = pending_powers.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for modular_exponentiation_64. A directed set covers
// zero and all-ones fields, bases at or above the modulus, a modulus of one
// and of all ones; random phases then run under new moduli. The sender
// transfers in bursts with random gaps, the receiver stalls on its own
// pattern, and mexp_scoreboard does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import mexp_pkg::*;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] TOP_BIT  = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [WORD_BITS-1:0] base      = '0;
  logic [WORD_BITS-1:0] exponent  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_BITS-1:0] power;
  logic                 cfg_write = 1'b0;
  logic [WORD_BITS-1:0] cfg_data  = '0;

  int                   mismatches;
  int                   outstanding;
  int unsigned          burst_left = 0;
  bit                   steady     = 1'b0;
  int unsigned          stall_pct  = 0;
  int unsigned          stall_span = 0;
  logic [WORD_BITS-1:0] modulus_now = RESET_MODULUS;

  modular_exponentiation_64 uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .base     (base),
    .exponent (exponent),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power    (power),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  mexp_scoreboard checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .base       (base),
    .exponent   (exponent),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .power      (power),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: stall density is redrawn among 0, 25, 60 and 95 percent after each random span
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(50, 3000);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 95;
      endcase
    end else begin
      stall_span--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [WORD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] e);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = steady ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 4)
                                                 : $urandom_range(10, 300));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_modulus(input logic [WORD_BITS-1:0] m);
    drain();
    cfg_write   <= 1'b1;
    cfg_data    <= m;
    modulus_now = m;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= rand_word();
  endtask

  initial begin
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] e;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset modulus
    send_item('0, '0);
    send_item('0, 64'd5);
    send_item(ALL_ONES, '0);
    send_item(ALL_ONES, ALL_ONES);
    send_item(64'd2, 64'd1);
    send_item(RESET_MODULUS, 64'd3);
    send_item(RESET_MODULUS - 64'd1, 64'd2);
    send_item(RESET_MODULUS + 64'd5, 64'd1);
    send_item(64'd3, TOP_BIT);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    set_modulus(64'd1);
    send_item('0, '0);
    send_item(ALL_ONES, '0);
    send_item(ALL_ONES, ALL_ONES);
    send_item(64'd5, 64'd1);

    set_modulus(ALL_ONES);
    send_item(ALL_ONES - 64'd1, ALL_ONES);
    send_item(ALL_ONES, 64'd7);
    send_item(64'd2, 64'd64);
    send_item(ALL_ONES - 64'd1, 64'd2);

    set_modulus(64'd2);
    send_item(64'd3, ALL_ONES);
    send_item(64'd4, 64'd9);

    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 4))
        0: m = rand_word() | 64'd1;
        1: m = rand_word() | TOP_BIT;
        2: m = 64'($urandom_range(1, 1000));
        3: m = TOP_BIT;
        default: m = rand_word() >> $urandom_range(1, 60);
      endcase
      if (m == '0) begin
        m = 64'd1;
      end
      if (phase == 5) begin
        m = RESET_MODULUS;
      end
      set_modulus(m);
      steady = (phase == 2);
      repeat (13) begin
        case ($urandom_range(0, 3))
          0: b = rand_word();
          1: b = modulus_now - 64'($urandom_range(0, 3));
          2: b = 64'($urandom_range(0, 20));
          default: b = rand_word() % modulus_now;
        endcase
        case ($urandom_range(0, 4))
          0: e = 64'($urandom_range(0, 255));
          1: e = ALL_ONES;
          2: e = rand_word() & rand_word();
          default: e = rand_word();
        endcase
        send_item(b, e);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
